[sv/lcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the LBA to CHS request splitter.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Geometry and addressing limits
  localparam int LBA_W       = 32;
  localparam int CYL_W       = 11;
  localparam int HEADS_W     = 9;
  localparam int SPT_W       = 6;
  localparam int BPS_W       = 13;
  localparam int BUF_W       = 20;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CYL_W-1:0]   CYL_LIMIT  = 11'd1024;
  localparam logic [HEADS_W-1:0] HEAD_LIMIT = 9'd256;
  localparam logic [7:0]         FIXED_DISK = 8'h80;

  // Divider: dividend width and divisor width
  localparam int DIV_W    = LBA_W;
  localparam int DVS_W    = HEADS_W;
  localparam int DIV_CNTW = $clog2(DIV_W);

  // Result status codes
  localparam logic [1:0] STS_CHUNK = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_GEOM  = 2'd2;
  localparam logic [1:0] STS_IDLE  = 2'd3;

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPS  = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  drive;
    logic [31:0] start_lba;
    logic [15:0] sector_total;
    logic [19:0] buffer_address;
  } lcs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        last;
    logic        use_lba;
    logic [7:0]  drive_out;
    logic [15:0] chunk_sectors;
    logic [7:0]  cyl_low;
    logic [7:0]  sector_cyl_high;
    logic [7:0]  head;
    logic [15:0] buf_segment;
    logic [3:0]  buf_offset;
    logic [31:0] lba_out;
  } lcs_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } lcs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } lcs_div_rsp_t;

endpackage

[sv/lba_to_chs_request_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_to_chs_request_splitter
// Splits a disk read request into track-bounded CHS chunks or one LBA packet.
// ----------------------------------------------------------------------------
// A start request loads drive, LBA, sector count and buffer address; each
// start or next request then returns one result. A CHS chunk goes from
// acceptance to the output register through a geometry check, two
// bit-serial divisions through the shared divider (LBA by sectors per
// track, then the track by heads), a bit-serial shift-add for the buffer
// advance (chunk length times bytes per sector) and a load of the output
// register. LBA packets, start-time geometry errors, empty requests and
// next-while-idle answers go straight from acceptance to the output load;
// a next request that finds bad geometry passes through the geometry check
// first, and a cylinder past the limit is reported after both divisions.
// The block takes one request at a time; a finished result sits in the
// output register while the next request is accepted and worked on, and a
// new result waits until the output register is free.
// ----------------------------------------------------------------------------
module lba_to_chs_request_splitter (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lcs_pkg::lcs_in_t                    in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output lcs_pkg::lcs_out_t                   out_data,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_CHK  = 3'd1;  // geometry check, launch first divide
  localparam logic [2:0] ST_DIV1 = 3'd2;  // lba / spt
  localparam logic [2:0] ST_DIV2 = 3'd3;  // track / heads
  localparam logic [2:0] ST_MUL  = 3'd4;  // buffer += cnt * bps, bit-serial
  localparam logic [2:0] ST_PUT  = 3'd5;  // move result to output register

  logic [2:0] state_r;

  // configuration
  logic                         ext_r;
  logic [lcs_pkg::CYL_W-1:0]    cyl_cfg_r;
  logic [lcs_pkg::HEADS_W-1:0]  heads_r;
  logic [lcs_pkg::SPT_W-1:0]    spt_r;
  logic [lcs_pkg::BPS_W-1:0]    bps_r;

  // request state
  logic                         active_r;
  logic [lcs_pkg::LBA_W-1:0]    cur_lba_r;
  logic [lcs_pkg::CNT_W-1:0]    remaining_r;
  logic [lcs_pkg::BUF_W-1:0]    cur_buf_r;
  logic [7:0]                   cur_drive_r;

  // chunk working registers
  logic [lcs_pkg::SPT_W-1:0]    idx_r;
  logic [lcs_pkg::BUF_W-1:0]    mcand_r;
  logic [lcs_pkg::SPT_W-1:0]    mplier_r;

  lcs_pkg::lcs_out_t            res_r;
  lcs_pkg::lcs_out_t            out_r;
  logic                         out_valid_r;

  lcs_pkg::lcs_div_req_t        div_req;
  lcs_pkg::lcs_div_rsp_t        div_rsp;

  // derived geometry
  logic [lcs_pkg::HEADS_W-1:0]  hd;
  logic [lcs_pkg::CYL_W-1:0]    lim;
  logic                         geom_bad;
  logic                         in_go;
  logic                         put_go;

  // chunk math at the end of the second divide
  logic [lcs_pkg::SPT_W-1:0]    room;
  logic [lcs_pkg::SPT_W-1:0]    cnt;
  logic                         cyl_bad;
  logic [lcs_pkg::CNT_W-1:0]    rem_after;

  assign hd       = (heads_r > lcs_pkg::HEAD_LIMIT) ? lcs_pkg::HEAD_LIMIT : heads_r;
  assign lim      = (cyl_cfg_r > lcs_pkg::CYL_LIMIT) ? lcs_pkg::CYL_LIMIT : cyl_cfg_r;
  assign geom_bad = (spt_r == '0) || (heads_r == '0);

  assign in_stall = (state_r != ST_IDLE);
  assign in_go    = in_valid && !in_stall;
  assign put_go   = (state_r == ST_PUT) && (!out_valid_r || !out_stall);

  // room left on the track; idx < spt so this never wraps
  assign room      = spt_r - idx_r;
  assign cnt       = (remaining_r < {{(lcs_pkg::CNT_W-lcs_pkg::SPT_W){1'b0}}, room})
                     ? remaining_r[lcs_pkg::SPT_W-1:0] : room;
  assign rem_after = remaining_r - {{(lcs_pkg::CNT_W-lcs_pkg::SPT_W){1'b0}}, cnt};
  assign cyl_bad   = (|div_rsp.quotient[lcs_pkg::LBA_W-1:lcs_pkg::CYL_W])
                     || (div_rsp.quotient[lcs_pkg::CYL_W-1:0] >= lim);

  // shared divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = cur_lba_r;
    div_req.divisor  = {{(lcs_pkg::HEADS_W-lcs_pkg::SPT_W){1'b0}}, spt_r};
    if (state_r == ST_CHK) begin
      div_req.start = !geom_bad;
    end else if (state_r == ST_DIV1) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = div_rsp.quotient;
      div_req.divisor  = hd;
    end
  end

  lcs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r     <= 1'b0;
      cyl_cfg_r <= 11'd1024;
      heads_r   <= 9'd16;
      spt_r     <= 6'd63;
      bps_r     <= 13'd512;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lcs_pkg::CFG_EXT:  ext_r     <= cfg_data[0];
        lcs_pkg::CFG_CYL:  cyl_cfg_r <= cfg_data[lcs_pkg::CYL_W-1:0];
        lcs_pkg::CFG_HEAD: heads_r   <= cfg_data[lcs_pkg::HEADS_W-1:0];
        lcs_pkg::CFG_SPT:  spt_r     <= cfg_data[lcs_pkg::SPT_W-1:0];
        lcs_pkg::CFG_BPS:  bps_r     <= cfg_data[lcs_pkg::BPS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and request state; res_r is all zero whenever the
  // sequencer sits in ST_IDLE, so each state only fills in its fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      cur_lba_r   <= '0;
      remaining_r <= '0;
      cur_buf_r   <= '0;
      cur_drive_r <= '0;
      res_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_go) begin
            if (in_data.cmd == lcs_pkg::CMD_START) begin
              cur_drive_r <= in_data.drive;
              cur_lba_r   <= in_data.start_lba;
              remaining_r <= in_data.sector_total;
              cur_buf_r   <= in_data.buffer_address;
              active_r    <= 1'b0;
              res_r.drive_out <= in_data.drive;
              res_r.last      <= 1'b1;
              if (ext_r && (in_data.drive >= lcs_pkg::FIXED_DISK)) begin
                res_r.status        <= lcs_pkg::STS_CHUNK;
                res_r.use_lba       <= 1'b1;
                res_r.chunk_sectors <= in_data.sector_total;
                res_r.buf_segment   <= in_data.buffer_address[19:4];
                res_r.buf_offset    <= in_data.buffer_address[3:0];
                res_r.lba_out       <= in_data.start_lba;
                state_r             <= ST_PUT;
              end else if (geom_bad) begin
                res_r.status <= lcs_pkg::STS_GEOM;
                state_r      <= ST_PUT;
              end else if (in_data.sector_total == '0) begin
                res_r.status <= lcs_pkg::STS_EMPTY;
                state_r      <= ST_PUT;
              end else begin
                state_r <= ST_CHK;
              end
            end else if (!active_r) begin
              res_r.status <= lcs_pkg::STS_IDLE;
              state_r      <= ST_PUT;
            end else begin
              state_r <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          // geometry is rechecked on every chunk
          res_r.drive_out <= cur_drive_r;
          if (geom_bad) begin
            res_r.status <= lcs_pkg::STS_GEOM;
            res_r.last   <= 1'b1;
            active_r     <= 1'b0;
            state_r      <= ST_PUT;
          end else begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            idx_r   <= div_rsp.remainder[lcs_pkg::SPT_W-1:0];
            state_r <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            if (cyl_bad) begin
              res_r.status <= lcs_pkg::STS_GEOM;
              res_r.last   <= 1'b1;
              active_r     <= 1'b0;
              state_r      <= ST_PUT;
            end else begin
              res_r.status          <= lcs_pkg::STS_CHUNK;
              res_r.last            <= (rem_after == '0);
              res_r.chunk_sectors   <= {{(lcs_pkg::CNT_W-lcs_pkg::SPT_W){1'b0}}, cnt};
              res_r.cyl_low         <= div_rsp.quotient[7:0];
              // sector is 1..63, so the cylinder high bits just sit on top
              res_r.sector_cyl_high <= {div_rsp.quotient[9:8], idx_r + 1'b1};
              res_r.head            <= div_rsp.remainder[7:0];
              res_r.buf_segment     <= cur_buf_r[19:4];
              res_r.buf_offset      <= cur_buf_r[3:0];
              res_r.lba_out         <= cur_lba_r;
              remaining_r           <= rem_after;
              cur_lba_r             <= cur_lba_r + {{(lcs_pkg::LBA_W-lcs_pkg::SPT_W){1'b0}}, cnt};
              active_r              <= (rem_after != '0);
              mcand_r               <= {{(lcs_pkg::BUF_W-lcs_pkg::BPS_W){1'b0}}, bps_r};
              mplier_r              <= cnt;
              state_r               <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // one multiplier bit a cycle; shifts and sums wrap at 1 MiB
          if (mplier_r == '0) begin
            state_r <= ST_PUT;
          end else begin
            if (mplier_r[0]) begin
              cur_buf_r <= cur_buf_r + mcand_r;
            end
            mcand_r  <= {mcand_r[lcs_pkg::BUF_W-2:0], 1'b0};
            mplier_r <= {1'b0, mplier_r[lcs_pkg::SPT_W-1:1]};
          end
        end
        ST_PUT: begin
          if (put_go) begin
            res_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_go) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // an accepted request always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // divider results only arrive while the sequencer waits for them
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == ST_DIV1) || (state_r == ST_DIV2)))
    else $error("divider finished outside a divide state");

  // an open request always has sectors left
  a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (remaining_r != '0))
    else $error("request active with nothing remaining");

  // a CHS chunk holds one to sixty-three sectors
  a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
    (put_go && (res_r.status == lcs_pkg::STS_CHUNK) && !res_r.use_lba)
    |-> ((res_r.chunk_sectors != '0) && (res_r.chunk_sectors <= 16'd63)))
    else $error("CHS chunk length out of range");

endmodule

[sv/lcs_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcs_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcs_pkg::lcs_div_req_t req,
  output lcs_pkg::lcs_div_rsp_t rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [lcs_pkg::DIV_CNTW-1:0] cnt_r;
  logic [lcs_pkg::DIV_W-1:0]    quo_r;
  logic [lcs_pkg::DVS_W-1:0]    rem_r;
  logic [lcs_pkg::DVS_W-1:0]    dvs_r;

  logic [lcs_pkg::DVS_W:0]      trial;
  logic                         ge;
  logic [lcs_pkg::DVS_W-1:0]    rem_nxt;
  logic [lcs_pkg::DVS_W:0]      diff;

  // dividend shifts out of quo_r at the top while quotient bits enter below
  assign trial   = {rem_r, quo_r[lcs_pkg::DIV_W-1]};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[lcs_pkg::DVS_W-1:0] : trial[lcs_pkg::DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= lcs_pkg::DIV_CNTW'(lcs_pkg::DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[lcs_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
